@@ rtl/sitda_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// sitda_pkg
// Shared types and constants for the signed integer to decimal ASCII core.
// ============================================================================
package sitda_pkg;

   // Field widths.
   localparam int MAG_W       = 32;
   localparam int DIGIT_COUNT = 10;
   localparam int BCD_W       = 4 * DIGIT_COUNT;
   localparam int CODE_W      = 6;
   localparam int NDIG_W      = 4;

   // Shift-and-add-3 conversion: 32 shifts spread over eight register stages.
   localparam int STEPS_PER_STAGE = 4;
   localparam int DABBLE_STAGES   = MAG_W / STEPS_PER_STAGE;

   // Character codes.
   localparam logic [CODE_W-1:0] CHAR_MINUS = 6'd45;
   localparam logic [CODE_W-1:0] CHAR_ZERO  = 6'd48;

   // Payload that travels through the conversion stages.
   typedef struct packed {
      logic             neg;
      logic [BCD_W-1:0] bcd;
      logic [MAG_W-1:0] bin;
   } dabble_type;

   // Payload handed to the character serializer: digits left-aligned so the
   // most significant nonzero digit sits in the top nibble.
   typedef struct packed {
      logic              neg;
      logic [BCD_W-1:0]  bcd;
      logic [NDIG_W-1:0] ndig;
   } ser_load_type;

endpackage

@@ rtl/signed_int_to_decimal_ascii_core.sv @@
`timescale 1ns / 1ps
// ============================================================================
// signed_int_to_decimal_ascii_core
// Converts a signed 32-bit integer into its decimal ASCII text, one
// character per output transfer, with the last character marked.
// ============================================================================
// Each number passes a sign/magnitude stage, eight shift-and-add-3 stages of
// four steps each and a digit alignment stage, each with its own register,
// then enters the character serializer, whose register offers the first
// character.
// The serializer emits one character per cycle while the output is ready,
// so a number holds it for all its characters: 1 to 10 digits plus a
// minus sign when negative, at most 11, which sets the sustained rate.
// New numbers keep entering the stage pipeline while the serializer is busy
// or the output is stalled, up to eleven in flight, one in the serializer.
// ============================================================================
module signed_int_to_decimal_ascii_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [31:0]            req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [sitda_pkg::CODE_W-1:0]  rsp_char_code,
   output logic                          rsp_last
);

   localparam int NS = sitda_pkg::DABBLE_STAGES;

   logic [sitda_pkg::MAG_W-1:0] raw;
   logic                        front_valid_ff;
   sitda_pkg::dabble_type       front_data_ff;
   sitda_pkg::dabble_type       front_data_in;

   logic                        stage_valid [0:NS];
   logic                        stage_ready [0:NS];
   sitda_pkg::dabble_type       stage_data  [0:NS];

   logic                        align_valid_ff;
   sitda_pkg::ser_load_type     align_data_ff;
   sitda_pkg::ser_load_type     align_data_in;
   logic                        align_ready;
   logic                        ser_ready;
   logic [sitda_pkg::BCD_W-1:0] conv_bcd;

   // Sign and magnitude: the most negative value becomes 2147483648.
   assign raw                 = req_value;
   assign front_data_in.neg   = raw[sitda_pkg::MAG_W-1];
   assign front_data_in.bcd   = '0;
   assign front_data_in.bin   = raw[sitda_pkg::MAG_W-1] ? (~raw + 32'd1) : raw;
   assign req_ready           = !front_valid_ff || stage_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (req_ready) begin
         front_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         front_data_ff <= front_data_in;
      end
   end

   assign stage_valid[0] = front_valid_ff;
   assign stage_data[0]  = front_data_ff;

   // Binary to BCD conversion pipeline.
   for (genvar g = 0; g < NS; g++) begin : g_dabble
      sitda_dabble_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[g]),
         .in_ready  (stage_ready[g]),
         .in_data   (stage_data[g]),
         .out_valid (stage_valid[g+1]),
         .out_ready (stage_ready[g+1]),
         .out_data  (stage_data[g+1])
      );
   end

   // Digit count and left alignment of the most significant nonzero digit.
   assign conv_bcd = stage_data[NS].bcd;

   always_comb begin
      align_data_in.neg  = stage_data[NS].neg;
      align_data_in.ndig = sitda_pkg::NDIG_W'(1);
      for (int n = 1; n < sitda_pkg::DIGIT_COUNT; n++) begin
         if (conv_bcd[4*n +: 4] != 4'd0) begin
            align_data_in.ndig = sitda_pkg::NDIG_W'(n + 1);
         end
      end
      align_data_in.bcd = conv_bcd;
      for (int k = 1; k <= sitda_pkg::DIGIT_COUNT; k++) begin
         if (align_data_in.ndig == sitda_pkg::NDIG_W'(k)) begin
            align_data_in.bcd = conv_bcd << (4 * (sitda_pkg::DIGIT_COUNT - k));
         end
      end
   end

   assign align_ready      = !align_valid_ff || ser_ready;
   assign stage_ready[NS]  = align_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         align_valid_ff <= 1'b0;
      end else if (align_ready) begin
         align_valid_ff <= stage_valid[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (align_ready && stage_valid[NS]) begin
         align_data_ff <= align_data_in;
      end
   end

   // Character output.
   sitda_serializer u_serializer (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (align_valid_ff),
      .in_ready      (ser_ready),
      .in_data       (align_data_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

endmodule

@@ rtl/sitda_dabble_stage.sv @@
`timescale 1ns / 1ps
// ============================================================================
// sitda_dabble_stage
// One pipeline stage of the binary to BCD converter: four shift-and-add-3
// steps followed by a register with its own valid bit.
// ============================================================================
module sitda_dabble_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  sitda_pkg::dabble_type  in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output sitda_pkg::dabble_type  out_data
);

   logic                   valid_ff;
   logic                   valid_in;
   sitda_pkg::dabble_type  data_ff;
   sitda_pkg::dabble_type  data_in;
   logic [sitda_pkg::BCD_W-1:0] bcd_v;
   logic [sitda_pkg::MAG_W-1:0] bin_v;

   // The stage can take a transfer when it is empty or its item moves on.
   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // Four conversion steps: correct every digit that is five or more, then
   // shift the next binary bit into the BCD word.
   always_comb begin
      bcd_v = in_data.bcd;
      bin_v = in_data.bin;
      for (int s = 0; s < sitda_pkg::STEPS_PER_STAGE; s++) begin
         for (int n = 0; n < sitda_pkg::DIGIT_COUNT; n++) begin
            if (bcd_v[4*n +: 4] >= 4'd5) begin
               bcd_v[4*n +: 4] = bcd_v[4*n +: 4] + 4'd3;
            end
         end
         bcd_v = {bcd_v[sitda_pkg::BCD_W-2:0], bin_v[sitda_pkg::MAG_W-1]};
         bin_v = {bin_v[sitda_pkg::MAG_W-2:0], 1'b0};
      end
      data_in.neg = in_data.neg;
      data_in.bcd = bcd_v;
      data_in.bin = bin_v;
   end

   assign valid_in = in_ready ? in_valid : valid_ff;

   // Valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload register, loaded only with a new item.
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

@@ rtl/sitda_serializer.sv @@
`timescale 1ns / 1ps
// ============================================================================
// sitda_serializer
// Holds one converted number and presents its characters one per transfer:
// the minus sign when negative, then the significant digits.
// ============================================================================
module sitda_serializer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  sitda_pkg::ser_load_type       in_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [sitda_pkg::CODE_W-1:0]  rsp_char_code,
   output logic                          rsp_last
);

   logic                              valid_ff;
   logic                              valid_in;
   logic                              neg_ff;
   logic                              neg_in;
   logic [sitda_pkg::BCD_W-1:0]       bcd_ff;
   logic [sitda_pkg::BCD_W-1:0]       bcd_in;
   logic [sitda_pkg::NDIG_W-1:0]      left_ff;
   logic [sitda_pkg::NDIG_W-1:0]      left_in;
   logic                              xfer;
   logic                              done;

   // Current character: the sign while it is pending, else the top digit.
   assign rsp_valid     = valid_ff;
   assign rsp_last      = !neg_ff && (left_ff == sitda_pkg::NDIG_W'(1));
   assign rsp_char_code = neg_ff ? sitda_pkg::CHAR_MINUS
                        : sitda_pkg::CHAR_ZERO
                          + {2'b00, bcd_ff[sitda_pkg::BCD_W-1 -: 4]};

   assign xfer     = valid_ff && rsp_ready;
   assign done     = xfer && rsp_last;
   assign in_ready = !valid_ff || done;

   // Next state: load a new number, or step to the next character.
   always_comb begin
      valid_in = valid_ff;
      neg_in   = neg_ff;
      bcd_in   = bcd_ff;
      left_in  = left_ff;
      if (in_ready) begin
         valid_in = in_valid;
         neg_in   = in_data.neg;
         bcd_in   = in_data.bcd;
         left_in  = in_data.ndig;
      end else if (xfer) begin
         if (neg_ff) begin
            neg_in = 1'b0;
         end else begin
            bcd_in  = {bcd_ff[sitda_pkg::BCD_W-5:0], 4'd0};
            left_in = left_ff - sitda_pkg::NDIG_W'(1);
         end
      end
   end

   // Valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Character state.
   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      bcd_ff  <= bcd_in;
      left_ff <= left_in;
   end

endmodule

@@ rtl/sitda_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// sitda_checker
// Port-level checks for the signed integer to decimal ASCII core.
// ============================================================================
module sitda_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [sitda_pkg::CODE_W-1:0]  rsp_char_code,
   input  logic                          rsp_last
);

   logic minus_shown;
   logic digit_shown;
   logic nonzero_digit;

   assign minus_shown   = rsp_char_code == sitda_pkg::CHAR_MINUS;
   assign digit_shown   = (rsp_char_code >= sitda_pkg::CHAR_ZERO)
                       && (rsp_char_code <= sitda_pkg::CHAR_ZERO + 6'd9);
   assign nonzero_digit = digit_shown && (rsp_char_code != sitda_pkg::CHAR_ZERO);

   // No result is offered in the cycle after reset.
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

   // A stalled result keeps its character and last mark.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char_code)
                                  && $stable(rsp_last))
      else $error("stalled result changed");

   // Only the minus sign or a digit is ever shown.
   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> minus_shown || digit_shown)
      else $error("illegal character code");

   // The minus sign never ends a number.
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && minus_shown |-> !rsp_last)
      else $error("minus sign marked last");

   // The sign is followed at once by a nonzero leading digit.
   a_after_minus: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && minus_shown |=> rsp_valid && nonzero_digit)
      else $error("minus sign not followed by a leading digit");

endmodule

bind signed_int_to_decimal_ascii_core sitda_checker u_sitda_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_char_code (rsp_char_code),
   .rsp_last      (rsp_last)
);

@@ bench/tb_signed_int_to_decimal_ascii_core.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_signed_int_to_decimal_ascii_core
// Self-checking bench for the signed integer to decimal ASCII core. A short
// table of hand-picked numbers comes first: extremes, zero, numbers with
// inner zeros, and numbers of 1, 2, 3, 6, 9 and 10 digits. About 360 random
// numbers follow, weighted toward every digit count. Each accepted number
// is turned into its expected character string, either from the text typed
// in the table or from a local decimal conversion. Every output transfer is
// compared against that string. Both sides idle at random, and the receiver
// once holds off long enough to fill the core and stall its input.
// ============================================================================
module tb_signed_int_to_decimal_ascii_core;

   localparam int RANDOM_COUNT = 360;
   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam int REPORT_LIMIT = 10;

   // Idling mix of the sender and the receiver.
   typedef enum logic [1:0] {
      IDLE_RX_HEAVY,
      IDLE_TX_HEAVY,
      IDLE_NONE
   } idle_mode_type;

   typedef logic [sitda_pkg::CODE_W-1:0] code_q_type[$];

   typedef struct packed {
      logic [sitda_pkg::CODE_W-1:0] code;
      logic                         last;
   } text_char_type;

   typedef struct {
      logic [31:0] value;
      string       text;
   } number_row_type;

   logic                             clock;
   logic                             reset     = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic signed [31:0]               req_value = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [sitda_pkg::CODE_W-1:0]     rsp_char_code;
   logic                             rsp_last;

   idle_mode_type            idle_mode = IDLE_RX_HEAVY;
   bit                       hold_rsp  = 1'b0;
   text_char_type            expected_chars[$];
   int                       error_count  = 0;
   int                       stall_cycles = 0;

   // Hand-picked numbers; the text is typed only where it is obvious.
   number_row_type directed_rows [22] = '{
      '{32'sd0,            "0"},
      '{32'sd1,            "1"},
      '{-32'sd1,           "-1"},
      '{32'sd9,            ""},
      '{32'sd10,           ""},
      '{-32'sd10,          ""},
      '{32'sd99,           ""},
      '{-32'sd100,         ""},
      '{32'sd1000000000,   "1000000000"},
      '{-32'sd1000000000,  "-1000000000"},
      '{32'sd999999999,    ""},
      '{-32'sd999999999,   ""},
      '{32'sh7fffffff,     "2147483647"},
      '{32'sh80000000,     "-2147483648"},
      '{32'sh80000001,     "-2147483647"},
      '{32'sd2000000008,   ""},
      '{-32'sd1000000001,  ""},
      '{32'sd100000,       ""},
      '{-32'sd7,           ""},
      '{32'sd1234567890,   ""},
      '{-32'sd55,          ""},
      '{32'sd0,            "0"}
   };

   signed_int_to_decimal_ascii_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Decimal text of a two's complement number: sign, then digits without
   // leading zeros. The most negative value negates to 2147483648 unsigned.
   function automatic code_q_type decimal_text(input logic [31:0] value);
      code_q_type  codes;
      logic [31:0] mag;
      logic [31:0] weight;
      logic [3:0]  digit;
      bit          started;
      started = 1'b0;
      weight  = 32'd1000000000;
      mag     = value[31] ? (~value + 32'd1) : value;
      if (value[31]) begin
         codes.push_back(sitda_pkg::CHAR_MINUS);
      end
      for (int d = 0; d < sitda_pkg::DIGIT_COUNT; d++) begin
         digit = 4'(mag / weight);
         mag   = mag % weight;
         if (digit != 4'd0 || started || d == sitda_pkg::DIGIT_COUNT - 1) begin
            started = 1'b1;
            codes.push_back(sitda_pkg::CHAR_ZERO + sitda_pkg::CODE_W'(digit));
         end
         weight = weight / 32'd10;
      end
      return codes;
   endfunction

   // Random numbers: full-range words, numbers of a chosen digit count, and
   // the extremes now and then.
   function automatic logic [31:0] random_value();
      int unsigned pick;
      int unsigned ndig;
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] value;
      pick = $urandom_range(99);
      if (pick < 45) begin
         value = $urandom;
      end else if (pick < 90) begin
         ndig = $urandom_range(10, 1);
         lo   = 32'd1;
         repeat (ndig - 1) lo = lo * 32'd10;
         hi   = (ndig == 10) ? 32'h7fffffff : lo * 32'd10 - 32'd1;
         if (ndig == 1) begin
            lo = 32'd0;
         end
         value = $urandom_range(hi, lo);
         if ($urandom_range(1) == 1) begin
            value = -value;
         end
      end else begin
         case ($urandom_range(3))
            0: value = 32'h00000000;
            1: value = 32'h80000000;
            2: value = 32'h7fffffff;
            default: value = 32'hffffffff;
         endcase
      end
      return value;
   endfunction

   function automatic void flag_error(input string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT) begin
         $display("%0t: %s", $realtime, msg);
      end
   endfunction

   // Offer one number, wait for its transfer, then queue its characters.
   task automatic send_number(input logic [31:0] value, input string text);
      code_q_type codes;
      byte        ch;
      while ($urandom_range(99) <
             ((idle_mode == IDLE_RX_HEAVY) ? 20 : (idle_mode == IDLE_TX_HEAVY) ? 47 : 0)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (text.len() != 0) begin
         for (int k = 0; k < text.len(); k++) begin
            ch = text.getc(k);
            codes.push_back(ch[sitda_pkg::CODE_W-1:0]);
         end
      end else begin
         codes = decimal_text(value);
      end
      foreach (codes[k]) begin
         expected_chars.push_back('{codes[k], (k == codes.size() - 1)});
      end
   endtask

   // Receiver: random ready, plus one long hold-off once it is requested.
   initial begin : rsp_ready_driver
      bit hold_done;
      hold_done = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_rsp && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >=
               ((idle_mode == IDLE_RX_HEAVY) ? 47 : (idle_mode == IDLE_TX_HEAVY) ? 20 : 0));
            @(posedge clock);
         end
      end
   end

   // Compare each output transfer with the oldest expected character.
   always @(posedge clock) begin : char_check
      text_char_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_chars.size() == 0) begin
            flag_error($sformatf("unexpected character: code %0d last %0b",
                                 rsp_char_code, rsp_last));
         end else begin
            want = expected_chars.pop_front();
            if (rsp_char_code !== want.code || rsp_last !== want.last) begin
               flag_error($sformatf(
                  "mismatch: expected code %0d last %0b, got code %0d last %0b",
                  want.code, want.last, rsp_char_code, rsp_last));
            end
         end
      end
   end

   // Watchdog: end the run when no transfer happens for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
         $display("** signed_int_to_decimal_ascii_core: FAILED **");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Stimulus: reset, the table, then three random phases, then drain.
   initial begin : stimulus
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) begin
         send_number(directed_rows[i].value, directed_rows[i].text);
      end
      for (int i = 0; i < RANDOM_COUNT; i++) begin
         if (i == RANDOM_COUNT / 3) begin
            idle_mode = IDLE_TX_HEAVY;
         end
         if (i == 2 * RANDOM_COUNT / 3) begin
            idle_mode = IDLE_NONE;
            hold_rsp  = 1'b1;
         end
         send_number(random_value(), "");
      end
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("** signed_int_to_decimal_ascii_core: PASSED **");
      end else begin
         $display("** signed_int_to_decimal_ascii_core: FAILED **");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/sitda_pkg.sv
rtl/sitda_dabble_stage.sv
rtl/sitda_serializer.sv
rtl/signed_int_to_decimal_ascii_core.sv
rtl/sitda_checker.sv
bench/tb_signed_int_to_decimal_ascii_core.sv
